// File: src/hswt_pkg.sv
// Shared types and constants for the halfword and signed-byte transfer unit.
package hswt_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned HalfWidth = 16;
   localparam int unsigned ImmWidth  = 8;

   typedef enum logic [1:0] {
      KIND_STRH  = 2'd0,
      KIND_LDRH  = 2'd1,
      KIND_LDRSH = 2'd2,
      KIND_LDRSB = 2'd3
   } kind_type;

   // Addressing-mode bits of one item.
   typedef struct packed {
      logic pre_index;
      logic add_offset;
      logic immediate_form;
      logic writeback_request;
   } addr_ctrl_type;

   // What the address unit hands back to the top level.
   typedef struct packed {
      logic [WordWidth-1:0] mem_address;
      logic [WordWidth-1:0] updated_base;
      logic                 upper_half;
   } addr_result_type;

endpackage

// File: src/hswt_addr.sv
// Offset adder, index selection and access address alignment.
module hswt_addr import hswt_pkg::*; (
   input  kind_type                kind,
   input  addr_ctrl_type           ctrl,
   input  logic [ImmWidth-1:0]     imm_offset,
   input  logic [WordWidth-1:0]    base_value,
   input  logic [WordWidth-1:0]    offset_reg_value,
   output addr_result_type         result
);

   logic [WordWidth-1:0] offset;
   logic [WordWidth-1:0] updated;
   logic [WordWidth-1:0] eff_addr;

   assign offset   = ctrl.immediate_form ? {{(WordWidth-ImmWidth){1'b0}}, imm_offset}
                                         : offset_reg_value;
   assign updated  = ctrl.add_offset ? (base_value + offset) : (base_value - offset);
   assign eff_addr = ctrl.pre_index ? updated : base_value;

   always_comb begin
      result.updated_base = updated;
      result.upper_half   = eff_addr[1];
      unique case (kind)
         KIND_STRH:              result.mem_address = {eff_addr[WordWidth-1:1], 1'b0};
         KIND_LDRH, KIND_LDRSH:  result.mem_address = {eff_addr[WordWidth-1:2], 2'b00};
         KIND_LDRSB:             result.mem_address = eff_addr;
         default:                result.mem_address = eff_addr;
      endcase
   end

endmodule

// File: src/hswt_load.sv
// Halfword or byte selection and extension of the memory reply.
module hswt_load import hswt_pkg::*; (
   input  kind_type               kind,
   input  logic                   upper_half,
   input  logic [WordWidth-1:0]   read_data,
   output logic [WordWidth-1:0]   load_value
);

   logic [HalfWidth-1:0] half;

   assign half = upper_half ? read_data[WordWidth-1:HalfWidth] : read_data[HalfWidth-1:0];

   always_comb begin
      unique case (kind)
         KIND_LDRH:
            load_value = {{(WordWidth-HalfWidth){1'b0}}, half};
         KIND_LDRSH:
            load_value = {{(WordWidth-HalfWidth){half[HalfWidth-1]}}, half};
         KIND_LDRSB:
            load_value = {{(WordWidth-8){read_data[7]}}, read_data[7:0]};
         default:
            load_value = '0;
      endcase
   end

endmodule

// File: src/halfword_signed_transfer_unit.sv
// Top level of the halfword and signed-byte transfer unit.
//
// An item (one STRH, LDRH, LDRSH or LDRSB transfer with its operands and
// the memory reply) is accepted on a rising edge with start high and busy
// low. busy is always low, so one item can be accepted in every cycle.
// The item is captured in an input register; the offset adder, address
// alignment and load extension sit between that register and the result
// register. The result appears on the rsp_ ports once it reaches the result
// register, for exactly one cycle with rsp_strobe high. Throughput is one
// item per cycle, since busy never rises and each register stage holds one
// item that moves on at every edge.
// The receiver cannot stall; results are simply presented and taken.
// An abort clears the register writes and their data; the address and
// store data keep their values. Reset drops any item in flight and
// clears the strobe.
module halfword_signed_transfer_unit import hswt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_type,
   input  logic                  req_pre_index,
   input  logic                  req_add_offset,
   input  logic                  req_immediate_form,
   input  logic                  req_writeback_request,
   input  logic [ImmWidth-1:0]   req_imm_offset,
   input  logic [WordWidth-1:0]  req_base_value,
   input  logic [WordWidth-1:0]  req_offset_reg_value,
   input  logic [WordWidth-1:0]  req_store_value,
   input  logic [WordWidth-1:0]  req_read_data,
   input  logic                  req_abort,
   output logic                  rsp_strobe,
   output logic [WordWidth-1:0]  rsp_mem_address,
   output logic [HalfWidth-1:0]  rsp_store_halfword,
   output logic [WordWidth-1:0]  rsp_load_value,
   output logic                  rsp_dest_write,
   output logic                  rsp_base_write,
   output logic [WordWidth-1:0]  rsp_new_base
);

   // Input register.
   logic                 valid_ff;
   kind_type             kind_ff;
   addr_ctrl_type        ctrl_ff;
   logic [ImmWidth-1:0]  imm_ff;
   logic [WordWidth-1:0] base_ff;
   logic [WordWidth-1:0] roff_ff;
   logic [HalfWidth-1:0] sval_ff;
   logic [WordWidth-1:0] rdata_ff;
   logic                 abort_ff;

   // Result register.
   logic                 strobe_ff;
   logic [WordWidth-1:0] addr_ff, addr_in;
   logic [HalfWidth-1:0] sh_ff, sh_in;
   logic [WordWidth-1:0] lv_ff, lv_in;
   logic                 dw_ff, dw_in;
   logic                 bw_ff, bw_in;
   logic [WordWidth-1:0] nb_ff, nb_in;

   logic                 accept;
   addr_result_type      addr_res;
   logic [WordWidth-1:0] load_ext;
   logic                 is_load;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= accept;
         strobe_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind_type'(req_type);
         ctrl_ff  <= '{pre_index:         req_pre_index,
                       add_offset:        req_add_offset,
                       immediate_form:    req_immediate_form,
                       writeback_request: req_writeback_request};
         imm_ff   <= req_imm_offset;
         base_ff  <= req_base_value;
         roff_ff  <= req_offset_reg_value;
         sval_ff  <= req_store_value[HalfWidth-1:0];
         rdata_ff <= req_read_data;
         abort_ff <= req_abort;
      end
   end

   hswt_addr u_addr (
      .kind             (kind_ff),
      .ctrl             (ctrl_ff),
      .imm_offset       (imm_ff),
      .base_value       (base_ff),
      .offset_reg_value (roff_ff),
      .result           (addr_res)
   );

   hswt_load u_load (
      .kind       (kind_ff),
      .upper_half (addr_res.upper_half),
      .read_data  (rdata_ff),
      .load_value (load_ext)
   );

   always_comb begin
      is_load = (kind_ff != KIND_STRH);
      addr_in = addr_res.mem_address;
      sh_in   = is_load ? '0 : sval_ff;
      dw_in   = is_load && !abort_ff;
      lv_in   = dw_in ? load_ext : '0;
      // Unless aborted, post-indexing always writes the base back; pre-indexing only on request.
      bw_in   = !abort_ff && (!ctrl_ff.pre_index || ctrl_ff.writeback_request);
      nb_in   = bw_in ? addr_res.updated_base : '0;
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         addr_ff <= addr_in;
         sh_ff   <= sh_in;
         lv_ff   <= lv_in;
         dw_ff   <= dw_in;
         bw_ff   <= bw_in;
         nb_ff   <= nb_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_mem_address    = addr_ff;
   assign rsp_store_halfword = sh_ff;
   assign rsp_load_value     = lv_ff;
   assign rsp_dest_write     = dw_ff;
   assign rsp_base_write     = bw_ff;
   assign rsp_new_base       = nb_ff;

   // Every accepted item yields exactly one result, through the input and result registers.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("accepted item produced no result");

   // A store result always carries a halfword-aligned address.
   a_store_aligned: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_STRH) |=> (rsp_mem_address[0] == 1'b0))
      else $error("store address not halfword aligned");

   // A load that writes its destination never drives store data.
   a_load_no_store: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_dest_write) |-> (rsp_store_halfword == '0))
      else $error("load result carries store data");

   // An aborted item writes neither register.
   a_abort_no_write: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && abort_ff) |=> (!rsp_dest_write && !rsp_base_write))
      else $error("aborted item wrote a register");

   // Without a base write the new base reads as zero.
   a_no_base_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_base_write) |-> (rsp_new_base == '0))
      else $error("new base nonzero without base write");

endmodule

// File: test/tb.sv
// Self-checking testbench for the halfword and signed-byte transfer unit.
`timescale 1ns / 100ps

module tb;
   import hswt_pkg::*;

   localparam int StallLimit = 2000;
   localparam int RandomItems = 1700;

   typedef struct {
      kind_type             kind;
      logic                 pre_index;
      logic                 add_offset;
      logic                 immediate_form;
      logic                 writeback_request;
      logic [ImmWidth-1:0]  imm_offset;
      logic [WordWidth-1:0] base_value;
      logic [WordWidth-1:0] offset_reg_value;
      logic [WordWidth-1:0] store_value;
      logic [WordWidth-1:0] read_data;
      logic                 abort;
   } xfer_item_type;

   typedef struct {
      logic [WordWidth-1:0] mem_address;
      logic [HalfWidth-1:0] store_halfword;
      logic [WordWidth-1:0] load_value;
      logic                 dest_write;
      logic                 base_write;
      logic [WordWidth-1:0] new_base;
   } xfer_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_type;
   logic                  req_pre_index;
   logic                  req_add_offset;
   logic                  req_immediate_form;
   logic                  req_writeback_request;
   logic [ImmWidth-1:0]   req_imm_offset;
   logic [WordWidth-1:0]  req_base_value;
   logic [WordWidth-1:0]  req_offset_reg_value;
   logic [WordWidth-1:0]  req_store_value;
   logic [WordWidth-1:0]  req_read_data;
   logic                  req_abort;
   logic                  rsp_strobe;
   logic [WordWidth-1:0]  rsp_mem_address;
   logic [HalfWidth-1:0]  rsp_store_halfword;
   logic [WordWidth-1:0]  rsp_load_value;
   logic                  rsp_dest_write;
   logic                  rsp_base_write;
   logic [WordWidth-1:0]  rsp_new_base;

   xfer_result_type pending_results[$];
   xfer_result_type checker_want;
   int mismatch_count = 0;
   int results_checked = 0;
   int store_count = 0;
   int load_count = 0;
   int abort_count = 0;
   int quiet_cycles = 0;

   halfword_signed_transfer_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_pre_index         (req_pre_index),
      .req_add_offset        (req_add_offset),
      .req_immediate_form    (req_immediate_form),
      .req_writeback_request (req_writeback_request),
      .req_imm_offset        (req_imm_offset),
      .req_base_value        (req_base_value),
      .req_offset_reg_value  (req_offset_reg_value),
      .req_store_value       (req_store_value),
      .req_read_data         (req_read_data),
      .req_abort             (req_abort),
      .rsp_strobe            (rsp_strobe),
      .rsp_mem_address       (rsp_mem_address),
      .rsp_store_halfword    (rsp_store_halfword),
      .rsp_load_value        (rsp_load_value),
      .rsp_dest_write        (rsp_dest_write),
      .rsp_base_write        (rsp_base_write),
      .rsp_new_base          (rsp_new_base)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic xfer_item_type make_item(kind_type kind, int pre, int add, int immf,
                                               int wb, logic [7:0] imm, logic [31:0] base,
                                               logic [31:0] roff, logic [31:0] sval,
                                               logic [31:0] rdata, int abt);
      xfer_item_type it;
      it.kind = kind;
      it.pre_index = pre[0];
      it.add_offset = add[0];
      it.immediate_form = immf[0];
      it.writeback_request = wb[0];
      it.imm_offset = imm;
      it.base_value = base;
      it.offset_reg_value = roff;
      it.store_value = sval;
      it.read_data = rdata;
      it.abort = abt[0];
      return it;
   endfunction

   // Computes the result that one transfer item must produce.
   function automatic xfer_result_type predict_transfer(xfer_item_type it);
      xfer_result_type r;
      logic [WordWidth-1:0] offset;
      logic [WordWidth-1:0] updated;
      logic [WordWidth-1:0] eff;
      logic [WordWidth-1:0] loaded;
      logic [HalfWidth-1:0] half;
      logic                 writes_base;
      offset = it.immediate_form ? {{(WordWidth-ImmWidth){1'b0}}, it.imm_offset}
                                 : it.offset_reg_value;
      updated = it.add_offset ? it.base_value + offset : it.base_value - offset;
      eff = it.pre_index ? updated : it.base_value;
      // Address bit 1 picks the upper halfword of the aligned word.
      half = eff[1] ? it.read_data[31:16] : it.read_data[15:0];
      r.store_halfword = '0;
      loaded = '0;
      case (it.kind)
         KIND_STRH: begin
            r.mem_address = {eff[31:1], 1'b0};
            r.store_halfword = it.store_value[15:0];
         end
         KIND_LDRH: begin
            r.mem_address = {eff[31:2], 2'b00};
            loaded = {16'd0, half};
         end
         KIND_LDRSH: begin
            r.mem_address = {eff[31:2], 2'b00};
            loaded = {{16{half[15]}}, half};
         end
         default: begin
            r.mem_address = eff;
            loaded = {{24{it.read_data[7]}}, it.read_data[7:0]};
         end
      endcase
      r.dest_write = (it.kind != KIND_STRH) && !it.abort;
      r.load_value = r.dest_write ? loaded : '0;
      writes_base = !it.abort && (!it.pre_index || it.writeback_request);
      r.base_write = writes_base;
      r.new_base = writes_base ? updated : '0;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic drive_fields(xfer_item_type it);
      req_type <= it.kind;
      req_pre_index <= it.pre_index;
      req_add_offset <= it.add_offset;
      req_immediate_form <= it.immediate_form;
      req_writeback_request <= it.writeback_request;
      req_imm_offset <= it.imm_offset;
      req_base_value <= it.base_value;
      req_offset_reg_value <= it.offset_reg_value;
      req_store_value <= it.store_value;
      req_read_data <= it.read_data;
      req_abort <= it.abort;
   endtask

   // Presents one item and returns on the edge that accepts it.
   task automatic send_transfer(xfer_item_type it);
      @(negedge clock);
      drive_fields(it);
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_transfer(it));
      if (it.kind == KIND_STRH) store_count++;
      else load_count++;
      if (it.abort) abort_count++;
   endtask

   task automatic hold_off(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic test_directed_corners();
      // Offset wraps, halfword selection, sign bits and the abort cases.
      send_transfer(make_item(KIND_STRH, 1, 1, 1, 1, 8'hff, 32'h0000_1000, 32'h0,
                              32'hdead_beef, 32'h0, 0));
      send_transfer(make_item(KIND_STRH, 0, 0, 0, 0, 8'h00, 32'h0000_0000, 32'h1,
                              32'hffff_0000, 32'hffff_ffff, 0));
      send_transfer(make_item(KIND_LDRH, 1, 1, 1, 0, 8'h02, 32'h0000_2000, 32'h0,
                              32'h0, 32'h8001_7fff, 0));
      send_transfer(make_item(KIND_LDRH, 0, 1, 1, 0, 8'h02, 32'h0000_2001, 32'h0,
                              32'h0, 32'h1234_ffff, 0));
      send_transfer(make_item(KIND_LDRSH, 1, 0, 0, 1, 8'h00, 32'h0000_3000, 32'h2,
                              32'h0, 32'h8000_0001, 0));
      send_transfer(make_item(KIND_LDRSH, 1, 1, 1, 1, 8'h04, 32'h0000_3000, 32'h0,
                              32'h0, 32'hffff_7fff, 0));
      send_transfer(make_item(KIND_LDRSH, 0, 1, 1, 0, 8'h00, 32'h0000_3002, 32'h0,
                              32'h0, 32'h7fff_8000, 0));
      send_transfer(make_item(KIND_LDRSB, 1, 1, 1, 0, 8'h03, 32'h0000_4000, 32'h0,
                              32'h0, 32'hffff_ff80, 0));
      send_transfer(make_item(KIND_LDRSB, 0, 0, 0, 0, 8'h00, 32'h0000_4003, 32'h8,
                              32'h0, 32'habcd_ef7f, 0));
      send_transfer(make_item(KIND_LDRH, 0, 1, 1, 1, 8'h10, 32'h0000_5002, 32'h0,
                              32'h0, 32'h5555_aaaa, 1));
      send_transfer(make_item(KIND_STRH, 1, 1, 1, 1, 8'h11, 32'h0000_6000, 32'h0,
                              32'h1234_5678, 32'h0, 1));
      send_transfer(make_item(KIND_LDRSB, 1, 0, 1, 1, 8'h01, 32'h0000_7000, 32'h0,
                              32'h0, 32'h0000_00ff, 1));
      send_transfer(make_item(KIND_LDRSH, 1, 1, 0, 0, 8'h00, 32'h0000_7000, 32'h2,
                              32'h0, 32'h9abc_def0, 1));
      // A writeback request on a post-indexed transfer changes nothing.
      send_transfer(make_item(KIND_LDRH, 0, 0, 1, 1, 8'h80, 32'h0000_8000, 32'h0,
                              32'h0, 32'hfedc_ba98, 0));
      send_transfer(make_item(KIND_STRH, 1, 0, 1, 0, 8'h01, 32'h0000_8000, 32'h0,
                              32'h0000_ffff, 32'h0, 0));
      send_transfer(make_item(KIND_LDRSB, 1, 1, 1, 1, 8'hff, 32'hffff_ffff, 32'h0,
                              32'h0, 32'h0000_0080, 0));
      send_transfer(make_item(KIND_LDRH, 1, 1, 0, 1, 8'hff, 32'h0000_9000, 32'hffff_ffff,
                              32'h0, 32'h0001_0002, 0));
      send_transfer(make_item(KIND_LDRSH, 0, 0, 0, 0, 8'h00, 32'h8000_0000, 32'h8000_0000,
                              32'h0, 32'hffff_ffff, 0));
      send_transfer(make_item(KIND_STRH, 0, 1, 0, 1, 8'hff, 32'hffff_fffe, 32'h4,
                              32'hffff_ffff, 32'hffff_ffff, 0));
      send_transfer(make_item(KIND_STRH, 0, 0, 0, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 0));
   endtask

   task automatic test_random_transfers(int count);
      xfer_item_type it;
      int pick;
      for (int i = 0; i < count; i++) begin
         it.kind = kind_type'($urandom_range(0, 3));
         it.pre_index = 1'($urandom_range(0, 1));
         it.add_offset = 1'($urandom_range(0, 1));
         it.immediate_form = 1'($urandom_range(0, 1));
         it.writeback_request = 1'($urandom_range(0, 1));
         it.imm_offset = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 3);
         // Bias the base toward both ends of the address space to hit the wraps.
         if (pick == 0) it.base_value = $urandom_range(0, 511);
         else if (pick == 1) it.base_value = 32'hffff_ff00 | $urandom_range(0, 255);
         else it.base_value = $urandom;
         it.offset_reg_value = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1023) : $urandom;
         it.store_value = $urandom;
         it.read_data = $urandom;
         it.abort = ($urandom_range(0, 9) == 0);
         send_transfer(it);
         // The middle stretch keeps start high in every cycle.
         if ((i < 600 || i >= 1000) && $urandom_range(0, 99) < 7) begin
            hold_off($urandom_range(1, 4));
         end
      end
   endtask

   task automatic test_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (pending_results.size() != 0) report_mismatch("missing results", 32'h0, 32'h0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_mem_address, 32'h0);
         end else begin
            checker_want = pending_results.pop_front();
            if (rsp_mem_address !== checker_want.mem_address)
               report_mismatch("mem_address", rsp_mem_address, checker_want.mem_address);
            if (rsp_store_halfword !== checker_want.store_halfword)
               report_mismatch("store_halfword", 32'(rsp_store_halfword),
                               32'(checker_want.store_halfword));
            if (rsp_load_value !== checker_want.load_value)
               report_mismatch("load_value", rsp_load_value, checker_want.load_value);
            if (rsp_dest_write !== checker_want.dest_write)
               report_mismatch("dest_write", 32'(rsp_dest_write),
                               32'(checker_want.dest_write));
            if (rsp_base_write !== checker_want.base_write)
               report_mismatch("base_write", 32'(rsp_base_write),
                               32'(checker_want.base_write));
            if (rsp_new_base !== checker_want.new_base)
               report_mismatch("new_base", rsp_new_base, checker_want.new_base);
            results_checked++;
         end
      end
   end

   // Ends the run if neither an item nor a result moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      drive_fields(make_item(KIND_STRH, 0, 0, 0, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 0));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_transfers(RandomItems);
      test_drain();
      $display("Sent %0d stores and %0d loads, %0d of them aborted.",
               store_count, load_count, abort_count);
      $display("Checked %0d results, found %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
